// ===== rtl/core/gmds_pkg.sv =====
package gmds_pkg;

	// field widths
	localparam int COORD_W = 6;
	localparam int IDX_W   = 12;
	localparam int COUNT_W = 13;

	// request codes
	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_SEARCH = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	// configuration register indexes
	localparam logic REG_GRID_COLS = 1'b0;
	localparam logic REG_GRID_ROWS = 1'b1;

	// grid size after reset
	localparam logic [COORD_W-1:0] GRID_RESET = 6'd3;
	localparam logic [COORD_W-1:0] GRID_MIN   = 6'd3;

	// search start cell
	localparam logic [COORD_W-1:0] START_X = 6'd1;
	localparam logic [COORD_W-1:0] START_Y = 6'd1;

	// neighbor order: down, up, right, left
	localparam logic [1:0] DIR_DOWN  = 2'd0;
	localparam logic [1:0] DIR_UP    = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_READ,
		ST_INIT,
		ST_PROBE,
		ST_CHECK,
		ST_POP,
		ST_POP_WAIT,
		ST_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clr_step;
		logic load_wr;
		logic rd_path;
		logic init;
		logic probe;
		logic found;
		logic push;
		logic next_dir;
		logic pop;
		logic pop_load;
		logic rsp_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic grid_small;
		logic at_goal;
		logic nbr_open;
		logic dir_last;
		logic count_one;
		logic rsp_free;
	} status_t;

endpackage

// ===== rtl/core/gmds_ctrl.sv =====
module gmds_ctrl
	import gmds_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_type,
	output logic       req_stall,
	input  status_t    st,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (st.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					unique case (req_type)
						REQ_SEARCH: state_d = ST_INIT;
						REQ_READ:   state_d = ST_READ;
						default:    state_d = ST_LOAD;
					endcase
				end
			end
			ST_LOAD: state_d = ST_RESULT;
			ST_READ: state_d = ST_RESULT;
			ST_INIT: begin
				state_d = st.grid_small ? ST_RESULT : ST_PROBE;
			end
			ST_PROBE: begin
				state_d = st.at_goal ? ST_RESULT : ST_CHECK;
			end
			ST_CHECK: begin
				if (st.nbr_open) state_d = ST_PROBE;
				else if (st.dir_last) state_d = ST_POP;
				else state_d = ST_PROBE;
			end
			ST_POP: begin
				state_d = st.count_one ? ST_RESULT : ST_POP_WAIT;
			end
			ST_POP_WAIT: state_d = ST_PROBE;
			ST_RESULT: begin
				if (st.rsp_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.capture = req_valid;
			end
			ST_LOAD: cmd.load_wr = 1'b1;
			ST_READ: cmd.rd_path = 1'b1;
			ST_INIT: cmd.init = 1'b1;
			ST_PROBE: begin
				cmd.found = st.at_goal;
				cmd.probe = !st.at_goal;
			end
			ST_CHECK: begin
				cmd.push = st.nbr_open;
				cmd.next_dir = !st.nbr_open && !st.dir_last;
			end
			ST_POP: cmd.pop = 1'b1;
			ST_POP_WAIT: cmd.pop_load = 1'b1;
			ST_RESULT: cmd.rsp_load = st.rsp_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/core/gmds_datapath.sv =====
module gmds_datapath
	import gmds_pkg::*;
#(
	parameter int MAX_DIM = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [COORD_W-1:0] cfg_wdata,
	input  logic [1:0]         req_type,
	input  logic [COORD_W-1:0] row,
	input  logic [COORD_W-1:0] col,
	input  logic               cell_open,
	input  logic [IDX_W-1:0]   path_index,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               found,
	output logic [COUNT_W-1:0] path_length,
	output logic [COORD_W-1:0] path_x,
	output logic [COORD_W-1:0] path_y,
	output logic               index_valid,
	input  cmd_t               cmd,
	output status_t            st
);

	localparam int CB        = $clog2(MAX_DIM);
	localparam int MAP_AW    = 2 * CB;
	localparam int MAP_DEPTH = 1 << MAP_AW;
	localparam int SDIM      = (MAX_DIM < 64) ? MAX_DIM : 64;
	localparam int STK_DEPTH = SDIM * SDIM;
	localparam int STK_AW    = $clog2(STK_DEPTH);

	// map address: row in the upper half, column in the lower half
	function automatic logic [MAP_AW-1:0] map_addr(input logic [COORD_W-1:0] y,
			input logic [COORD_W-1:0] x);
		return {CB'(y), CB'(x)};
	endfunction

	function automatic logic in_map(input logic [COORD_W:0] v);
		return int'(v) < MAX_DIM;
	endfunction

	// configuration and captured request
	logic [COORD_W-1:0] cols_q, rows_q;
	logic [1:0]         req_q;
	logic [COORD_W-1:0] row_q, col_q;
	logic               open_q;
	logic [IDX_W-1:0]   idx_q;

	// search state
	logic [COUNT_W-1:0] count_q;
	logic               goal_q;
	logic [COORD_W-1:0] tx_q, ty_q;
	logic [1:0]         dir_q;
	logic [MAP_AW-1:0]  clr_addr_q;

	// result register
	logic               rsp_valid_q;
	logic               found_q;
	logic [COUNT_W-1:0] length_q;
	logic [COORD_W-1:0] px_q, py_q;
	logic               ivalid_q;

	// memories
	logic                 map_mem [MAP_DEPTH];
	logic                 map_rdata_q;
	logic [2*COORD_W-1:0] stk_mem [STK_DEPTH];
	logic [2*COORD_W-1:0] stk_rdata_q;

	logic                 map_we, map_wdata, map_re;
	logic [MAP_AW-1:0]    map_waddr, map_raddr;
	logic                 stk_we, stk_re;
	logic [STK_AW-1:0]    stk_waddr, stk_raddr;
	logic [2*COORD_W-1:0] stk_wdata;

	logic [COORD_W:0]     nx7, ny7;
	logic                 nbr_in;
	logic                 grid_small;
	logic [COUNT_W-1:0]   cnt_m2;
	logic                 idx_ok;

	// neighbor of the top cell in the current direction
	always_comb begin
		nx7 = {1'b0, tx_q};
		ny7 = {1'b0, ty_q};
		unique case (dir_q)
			DIR_DOWN:  ny7 = {1'b0, ty_q} + 7'd1;
			DIR_UP:    ny7 = {1'b0, ty_q} - 7'd1;
			DIR_RIGHT: nx7 = {1'b0, tx_q} + 7'd1;
			DIR_LEFT:  nx7 = {1'b0, tx_q} - 7'd1;
		endcase
	end

	// a negative coordinate wraps into the top bit
	assign nbr_in = !nx7[COORD_W] && !ny7[COORD_W]
		&& (nx7[COORD_W-1:0] < cols_q) && (ny7[COORD_W-1:0] < rows_q)
		&& in_map(nx7) && in_map(ny7);

	assign grid_small = (cols_q < GRID_MIN) || (rows_q < GRID_MIN);
	assign cnt_m2     = count_q - 13'd2;
	assign idx_ok     = ({1'b0, idx_q} < count_q);

	// status
	always_comb begin
		st.clr_last   = &clr_addr_q;
		st.grid_small = grid_small;
		st.at_goal    = (tx_q == cols_q - 6'd2) && (ty_q == rows_q - 6'd2);
		st.nbr_open   = nbr_in && !map_rdata_q;
		st.dir_last   = (dir_q == DIR_LEFT);
		st.count_one  = (count_q == 13'd1);
		st.rsp_free   = !rsp_valid_q || !rsp_stall;
	end

	// map port select
	always_comb begin
		map_we    = 1'b0;
		map_waddr = clr_addr_q;
		map_wdata = 1'b1;
		if (cmd.clr_step) begin
			map_we = 1'b1;
		end else if (cmd.load_wr) begin
			map_we    = (req_q == REQ_LOAD) && in_map({1'b0, row_q}) && in_map({1'b0, col_q});
			map_waddr = map_addr(row_q, col_q);
			map_wdata = !open_q;
		end else if (cmd.init) begin
			map_we    = !grid_small;
			map_waddr = map_addr(START_Y, START_X);
		end else if (cmd.push) begin
			map_we    = 1'b1;
			map_waddr = map_addr(ny7[COORD_W-1:0], nx7[COORD_W-1:0]);
		end
		map_re    = cmd.probe;
		map_raddr = map_addr(ny7[COORD_W-1:0], nx7[COORD_W-1:0]);
	end

	// stack port select
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = count_q[STK_AW-1:0];
		stk_wdata = {ny7[COORD_W-1:0], nx7[COORD_W-1:0]};
		if (cmd.init) begin
			stk_we    = !grid_small;
			stk_waddr = '0;
			stk_wdata = {START_Y, START_X};
		end else if (cmd.push) begin
			stk_we = 1'b1;
		end
		stk_re    = cmd.rd_path || (cmd.pop && !st.count_one);
		stk_raddr = cmd.rd_path ? idx_q[STK_AW-1:0] : cnt_m2[STK_AW-1:0];
	end

	// blocked map
	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_waddr] <= map_wdata;
		if (map_re) map_rdata_q <= map_mem[map_raddr];
	end

	// path stack
	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
		if (stk_re) stk_rdata_q <= stk_mem[stk_raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= GRID_RESET;
			rows_q <= GRID_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_COLS: cols_q <= cfg_wdata;
				REG_GRID_ROWS: rows_q <= cfg_wdata;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_type;
			row_q  <= row;
			col_q  <= col;
			open_q <= cell_open;
			idx_q  <= path_index;
		end
	end

	// search control state and clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			goal_q     <= 1'b0;
			dir_q      <= DIR_DOWN;
			clr_addr_q <= '0;
		end else begin
			if (cmd.clr_step) clr_addr_q <= clr_addr_q + MAP_AW'(1);
			if (cmd.init) begin
				count_q <= grid_small ? 13'd0 : 13'd1;
				goal_q  <= 1'b0;
				dir_q   <= DIR_DOWN;
			end
			if (cmd.found) goal_q <= 1'b1;
			if (cmd.push) begin
				count_q <= count_q + 13'd1;
				dir_q   <= DIR_DOWN;
			end
			if (cmd.next_dir) dir_q <= dir_q + 2'd1;
			if (cmd.pop) count_q <= count_q - 13'd1;
			if (cmd.pop_load) dir_q <= DIR_DOWN;
		end
	end

	// top of stack cell
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			tx_q <= START_X;
			ty_q <= START_Y;
		end else if (cmd.push) begin
			tx_q <= nx7[COORD_W-1:0];
			ty_q <= ny7[COORD_W-1:0];
		end else if (cmd.pop_load) begin
			tx_q <= stk_rdata_q[COORD_W-1:0];
			ty_q <= stk_rdata_q[2*COORD_W-1:COORD_W];
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			found_q  <= goal_q;
			length_q <= count_q;
			if ((req_q == REQ_READ) && idx_ok) begin
				px_q     <= stk_rdata_q[COORD_W-1:0];
				py_q     <= stk_rdata_q[2*COORD_W-1:COORD_W];
				ivalid_q <= 1'b1;
			end else begin
				px_q     <= '0;
				py_q     <= '0;
				ivalid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign found       = found_q;
	assign path_length = length_q;
	assign path_x      = px_q;
	assign path_y      = py_q;
	assign index_valid = ivalid_q;

endmodule

// ===== rtl/core/grid_maze_dfs_solver.sv =====
// channel    | direction | handshake            | payload
// request    | in        | req_valid, req_stall | req_type, row, col, cell_open, path_index
// response   | out       | rsp_valid, rsp_stall | found, path_length, path_x, path_y,
//            |           |                      | index_valid
// config     | in        | cfg_we               | cfg_index, cfg_wdata
//
// load and read each pass through accept, one map or stack access, and result.
// a search runs init, then probe (goal check, neighbor map read) and check, which pushes
// an open neighbor or steps to the next direction, popping after the last one; it ends
// at the goal, when the stack empties or on a grid below the minimum size; the single
// map read port sets the walk speed. after reset the map is swept to blocked, one cell a
// cycle, through 2**(2*ceil(log2(MAX_DIM))) cells (4096 at 64); requests stall meanwhile.
// a finished result waits in the output register while the next transaction runs;
// the next result then waits as long as the output stays stalled.
module grid_maze_dfs_solver
	import gmds_pkg::*;
#(
	parameter int MAX_DIM = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [COORD_W-1:0] cfg_wdata,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         req_type,
	input  logic [COORD_W-1:0] row,
	input  logic [COORD_W-1:0] col,
	input  logic               cell_open,
	input  logic [IDX_W-1:0]   path_index,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               found,
	output logic [COUNT_W-1:0] path_length,
	output logic [COORD_W-1:0] path_x,
	output logic [COORD_W-1:0] path_y,
	output logic               index_valid
);

	cmd_t    cmd;
	status_t st;

	// search sequencer
	gmds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_type),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// map, stack and result registers
	gmds_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.req_type    (req_type),
		.row         (row),
		.col         (col),
		.cell_open   (cell_open),
		.path_index  (path_index),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.found       (found),
		.path_length (path_length),
		.path_x      (path_x),
		.path_y      (path_y),
		.index_valid (index_valid),
		.cmd         (cmd),
		.st          (st)
	);

endmodule
